[hdl/stirling_second_kind_mod_defines.svh]
// Assertion macros for the Stirling number block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef STIRLING_SECOND_KIND_MOD_DEFINES_SVH
`define STIRLING_SECOND_KIND_MOD_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define STIRL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("stirling block: assertion failed");

// Next-cycle implication, disabled while reset is active.
`define STIRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stirling block: assertion failed");

`endif

[hdl/stirl_pkg.sv]
// Shared constants for the Stirling number block: field widths and the
// modular reduction constants. No dependencies.
package stirl_pkg;

  localparam int IDX_W   = 11;  // ball and box count fields
  localparam int VAL_W   = 30;  // residues mod the prime
  localparam int MUL_A_W = 12;  // narrow multiplier operand
  localparam int MUL_W   = MUL_A_W + VAL_W;
  localparam int PROD_W  = 41;  // column * residue, column below 2^11
  localparam int REM_W   = 32;  // remainder before correction, below 4p

  localparam logic [VAL_W-1:0]   MODULUS   = 30'd1000000007;
  // floor(2^41 / p); quotient estimate = ((prod >> 29) * RECIP) >> 12
  localparam logic [MUL_A_W-1:0] RECIP     = 12'd2199;
  localparam int                 EST_SHIFT = 12;
  localparam logic [REM_W-1:0]   REM_BOUND = 32'd4000000028;

endpackage

[hdl/stirl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stirl_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/stirling_second_kind_mod.sv]
// Top level of the Stirling number (second kind) mod 1e9+7 engine.
// Depends on stirl_pkg, stirl_ram and stirling_second_kind_mod_defines.svh.
//
//   channel  direction  handshake                 payload
//   query    in         in_valid_i / in_ready_o   ball_count_i, box_count_i
//   answer   out        out_valid_o / out_ready_i ways_o
//
// Trivial queries (m = 0, m > n, n > MAX_N) go straight to the answer. Otherwise
// rows 1..n are swept, row i touching min(i,m) cells; each cell uses the one
// 12x30 multiplier three times (product, quotient estimate, quotient times p)
// and the single RAM read port.
// The row store needs no clearing: cells not yet written in a query are never
// used, their values are substituted by the sequencer. Reset is ready at once.
// A finished answer waits in the output register; the next query is taken
// meanwhile, and its answer holds in the sequencer until the slot frees up.
`include "stirling_second_kind_mod_defines.svh"

module stirling_second_kind_mod #(
  parameter int MAX_N = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [stirl_pkg::IDX_W-1:0] ball_count_i,
  input  logic [stirl_pkg::IDX_W-1:0] box_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [stirl_pkg::VAL_W-1:0] ways_o
);

  localparam int IW    = stirl_pkg::IDX_W;
  localparam int VW    = stirl_pkg::VAL_W;
  localparam int AW_M  = stirl_pkg::MUL_A_W;
  localparam int MW    = stirl_pkg::MUL_W;
  localparam int PW    = stirl_pkg::PROD_W;
  localparam int RW    = stirl_pkg::REM_W;
  localparam int Depth = MAX_N + 1;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = (AW > IW) ? AW : IW;

  typedef enum logic [3:0] {
    IDLE, ROW_RD, ROW_CAP, MUL_A, MUL_B, MUL_C, SUB, CORR, ADD, FIN_RD, FIN_CAP, DONE
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   n_q, m_q, i_q, j_q;
  logic [VW-1:0]   cur_q, below_q, res_q, ways_q;
  logic [PW-1:0]   prod_q;
  logic [MW-1:0]   mul_q;
  logic [RW-1:0]   rem_q;
  logic            out_valid_q;

  logic [AW_M-1:0] mul_a;
  logic [VW-1:0]   mul_b;
  logic [MW-1:0]   mul_p;
  logic [VW:0]     sum;
  logic [VW-1:0]   ram_wdata, ram_rdata, below_val;
  logic [AW-1:0]   ram_raddr, ram_waddr;
  logic            ram_we;
  logic [CW-1:0]   top_col;
  logic            out_load;

  // Shared multiplier: operands picked by the sequencer step
  always_comb begin
    case (state_q)
      MUL_A: begin
        mul_a = AW_M'(j_q[IW-1:0]);
        mul_b = cur_q;
      end
      MUL_B: begin
        mul_a = mul_q[PW-1 -: AW_M];
        mul_b = VW'(stirl_pkg::RECIP);
      end
      MUL_C: begin
        mul_a = mul_q[stirl_pkg::EST_SHIFT +: AW_M];
        mul_b = stirl_pkg::MODULUS;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MW'(mul_a) * MW'(mul_b);

  assign sum       = {1'b0, below_q} + {1'b0, rem_q[VW-1:0]};
  assign ram_wdata = (sum >= {1'b0, stirl_pkg::MODULUS}) ?
                     VW'(sum - {1'b0, stirl_pkg::MODULUS}) : sum[VW-1:0];
  assign top_col   = (i_q < m_q) ? i_q : m_q;
  // column 0 holds 1 only before the first row is done
  assign below_val = (j_q == CW'(1)) ? ((i_q == CW'(1)) ? VW'(1) : '0) : ram_rdata;

  always_comb begin
    case (state_q)
      ROW_RD:  ram_raddr = AW'(top_col);
      MUL_A:   ram_raddr = AW'(j_q - CW'(1));
      FIN_RD:  ram_raddr = AW'(m_q);
      default: ram_raddr = '0;
    endcase
  end

  assign ram_we    = (state_q == ADD);
  assign ram_waddr = AW'(j_q);

  // answer register free, or freed by this cycle's transaction
  assign out_load  = (state_q == DONE) && (!out_valid_q || out_ready_i);

  stirl_ram #(
    .WIDTH (VW),
    .DEPTH (Depth)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      m_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      cur_q       <= '0;
      below_q     <= '0;
      res_q       <= '0;
      ways_q      <= '0;
      prod_q      <= '0;
      mul_q       <= '0;
      rem_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        ways_q      <= res_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            if (box_count_i == '0) begin
              res_q   <= (ball_count_i == '0) ? VW'(1) : '0;
              state_q <= DONE;
            end else if ((box_count_i > ball_count_i) || (int'(ball_count_i) > MAX_N)) begin
              res_q   <= '0;
              state_q <= DONE;
            end else begin
              n_q     <= CW'(ball_count_i);
              m_q     <= CW'(box_count_i);
              i_q     <= CW'(1);
              state_q <= ROW_RD;
            end
          end
        end
        ROW_RD: begin
          j_q     <= top_col;
          state_q <= ROW_CAP;
        end
        ROW_CAP: begin
          // cell i is fresh in row i
          cur_q   <= (j_q == i_q) ? '0 : ram_rdata;
          state_q <= MUL_A;
        end
        MUL_A: begin
          mul_q   <= mul_p;
          state_q <= MUL_B;
        end
        MUL_B: begin
          prod_q  <= mul_q[PW-1:0];
          below_q <= below_val;
          mul_q   <= mul_p;
          state_q <= MUL_C;
        end
        MUL_C: begin
          mul_q   <= mul_p;
          state_q <= SUB;
        end
        SUB: begin
          // true difference is below 4p, so the low bits suffice
          rem_q   <= prod_q[RW-1:0] - mul_q[RW-1:0];
          state_q <= CORR;
        end
        CORR: begin
          if (rem_q >= RW'(stirl_pkg::MODULUS)) begin
            rem_q <= rem_q - RW'(stirl_pkg::MODULUS);
          end else begin
            state_q <= ADD;
          end
        end
        ADD: begin
          cur_q <= below_q;
          if (j_q == CW'(1)) begin
            if (i_q == n_q) begin
              state_q <= FIN_RD;
            end else begin
              i_q     <= i_q + CW'(1);
              state_q <= ROW_RD;
            end
          end else begin
            j_q     <= j_q - CW'(1);
            state_q <= MUL_A;
          end
        end
        FIN_RD: begin
          state_q <= FIN_CAP;
        end
        FIN_CAP: begin
          res_q   <= ram_rdata;
          state_q <= DONE;
        end
        DONE: begin
          if (out_load) begin
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = out_valid_q;
  assign ways_o      = ways_q;

  `STIRL_ASSERT_IMPL(a_wdata_reduced, clk_i, rst_ni, ram_we, ram_wdata < stirl_pkg::MODULUS)
  `STIRL_ASSERT_IMPL(a_rem_bound, clk_i, rst_ni, state_q == CORR, rem_q < stirl_pkg::REM_BOUND)
  `STIRL_ASSERT_IMPL(a_ways_reduced, clk_i, rst_ni, out_valid_o, ways_o < stirl_pkg::MODULUS)
  `STIRL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `STIRL_ASSERT_IMPL(a_column_range, clk_i, rst_ni, state_q == MUL_A, (j_q != '0) && (j_q <= i_q))

endmodule
